// ===== sv/ptd_pkg.sv =====
// ============================================================================
// ptd_pkg: shared types and constants for the periodic task tick dispatcher
// Slot count, field widths, stream packing, FSM states and the cell command.
// ============================================================================
package ptd_pkg;

  // Number of task slots (cells in the chain), 1 to 8
  localparam int TASK_SLOTS = 8;

  // Field widths
  localparam int SLOT_W = 3;
  localparam int CD_W   = 16;

  // Stream data widths (fields packed from bit 0, padded to bytes)
  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 8;

  // Input field positions in s_axis_tdata
  localparam int SLOT_LSB    = 0;
  localparam int PRESENT_LSB = SLOT_LSB + SLOT_W;
  localparam int PERIOD_LSB  = PRESENT_LSB + 1;
  localparam int DELAY_LSB   = PERIOD_LSB + CD_W;

  // Operation carried in tuser
  typedef enum logic {
    OP_TICK   = 1'b0,
    OP_CREATE = 1'b1
  } op_e;

  // Controller states
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } state_e;

  // Command broadcast from controller to every cell
  typedef struct packed {
    logic tick;  // update countdown, latch fire flag
    logic step;  // token moves one cell along
    logic take;  // cell holding the token clears its fire flag
    logic clr;   // drop the token everywhere at the end of a scan
  } cell_cmd_t;

endpackage

// ===== sv/periodic_task_tick_dispatcher_unit.sv =====
// ============================================================================
// periodic_task_tick_dispatcher_unit: time-triggered task tick dispatcher
// Top level: a chain of task slot cells walked by a token, plus controller.
// ============================================================================
// Usage:
//   Input stream (s_axis): tuser selects the operation, tick or create.
//   A create transaction writes one slot's present flag, period and initial
//   countdown; the next transaction can follow at once.
//   A tick transaction updates every slot in the same cycle and latches which
//   slots fire; a token then walks the cell chain, one cell per cycle unless
//   stalled, and every firing cell places its index in the output register.
//   Output stream (m_axis): tdata carries the fired slot index, tlast marks
//   the final fired slot of the tick. A tick with no firing emits nothing.
//   A tick holds the input not ready while the token walks up to the highest
//   firing slot. If the receiver stalls, the token holds at the firing cell
//   and the input stays not ready until the scan ends.
//   Reset clears every slot (absent, period and countdown zero) at once.
// ============================================================================
module periodic_task_tick_dispatcher_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Input stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [2:0] slot, [3] task_present, [19:4] period, [35:20] initial_delay
  input  logic [ptd_pkg::S_TDATA_W-1:0]    s_axis_tdata,
  // [0] operation
  input  logic                             s_axis_tuser,
  // Output stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [2:0] fired_slot
  output logic [ptd_pkg::M_TDATA_W-1:0]    m_axis_tdata,
  output logic                             m_axis_tlast
);
  import ptd_pkg::*;

  cell_cmd_t             cmd;
  logic                  inject;
  logic [TASK_SLOTS-1:0] tok_w;
  logic [TASK_SLOTS-1:0] fire_w;
  logic [TASK_SLOTS-1:0] wr_en;
  logic                  create_acc;
  logic [SLOT_W-1:0]     in_slot;
  logic [SLOT_W-1:0]     out_slot;

  assign in_slot    = s_axis_tdata[SLOT_LSB +: SLOT_W];
  assign create_acc = s_axis_tvalid && s_axis_tready
                      && (op_e'(s_axis_tuser) == OP_CREATE);

  // Slot cells
  for (genvar i = 0; i < TASK_SLOTS; i++) begin : g_cell
    logic tok_in;
    if (i == 0) begin : g_head
      assign tok_in = inject;
    end else begin : g_link
      assign tok_in = tok_w[i-1];
    end

    assign wr_en[i] = create_acc && (32'(in_slot) == 32'(i));

    ptd_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .wr_en_i      (wr_en[i]),
      .wr_present_i (s_axis_tdata[PRESENT_LSB]),
      .wr_period_i  (s_axis_tdata[PERIOD_LSB +: CD_W]),
      .wr_delay_i   (s_axis_tdata[DELAY_LSB +: CD_W]),
      .tok_i        (tok_in),
      .tok_o        (tok_w[i]),
      .fire_o       (fire_w[i])
    );
  end

  // Scan controller
  ptd_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_op_i    (s_axis_tuser),
    .s_ready_o (s_axis_tready),
    .tok_i     (tok_w),
    .fire_i    (fire_w),
    .cmd_o     (cmd),
    .inject_o  (inject),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_slot_o  (out_slot),
    .m_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {{(M_TDATA_W - SLOT_W){1'b0}}, out_slot};

endmodule

// ===== sv/ptd_cell.sv =====
// ============================================================================
// ptd_cell: one task slot of the dispatcher chain
// Holds present flag, period and countdown, latches a fire flag on a tick and
// passes the scan token to its neighbor.
// ============================================================================
module ptd_cell (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ptd_pkg::cell_cmd_t     cmd_i,
  input  logic                   wr_en_i,
  input  logic                   wr_present_i,
  input  logic [ptd_pkg::CD_W-1:0] wr_period_i,
  input  logic [ptd_pkg::CD_W-1:0] wr_delay_i,
  input  logic                   tok_i,
  output logic                   tok_o,
  output logic                   fire_o
);
  import ptd_pkg::*;

  logic            present_q;
  logic [CD_W-1:0] period_q;
  logic [CD_W-1:0] cd_q, cd_d;
  logic            fire_q, fire_d;
  logic            tok_q;
  logic            cd_zero;

  assign cd_zero = (cd_q == '0);

  // Countdown and fire flag update
  always_comb begin
    cd_d   = cd_q;
    fire_d = fire_q;
    if (cmd_i.tick) begin
      fire_d = present_q && cd_zero;
      if (!cd_zero) begin
        cd_d = cd_q - CD_W'(1);
      end else if (present_q) begin
        cd_d = period_q - CD_W'(1);
      end
    end else if (cmd_i.take && tok_q) begin
      fire_d = 1'b0;
    end
    if (wr_en_i) begin
      cd_d = wr_delay_i;
    end
  end

  // Slot state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= 1'b0;
      period_q  <= '0;
      cd_q      <= '0;
      fire_q    <= 1'b0;
      tok_q     <= 1'b0;
    end else begin
      cd_q   <= cd_d;
      fire_q <= fire_d;
      if (wr_en_i) begin
        present_q <= wr_present_i;
        period_q  <= wr_period_i;
      end
      if (cmd_i.clr) begin
        tok_q <= 1'b0;
      end else if (cmd_i.step) begin
        tok_q <= tok_i;
      end
    end
  end

  assign tok_o  = tok_q;
  assign fire_o = fire_q;

endmodule

// ===== sv/ptd_ctrl.sv =====
// ============================================================================
// ptd_ctrl: scan controller and output register
// Accepts transactions, steps the token along the cell chain and emits one
// output transaction per fired slot on the output stream.
// ============================================================================
module ptd_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_valid_i,
  input  logic                          s_op_i,
  output logic                          s_ready_o,
  input  logic [ptd_pkg::TASK_SLOTS-1:0] tok_i,
  input  logic [ptd_pkg::TASK_SLOTS-1:0] fire_i,
  output ptd_pkg::cell_cmd_t            cmd_o,
  output logic                          inject_o,
  output logic                          m_valid_o,
  input  logic                          m_ready_i,
  output logic [ptd_pkg::SLOT_W-1:0]    m_slot_o,
  output logic                          m_last_o
);
  import ptd_pkg::*;

  state_e                state_q, state_d;
  logic                  out_valid_q;
  logic [SLOT_W-1:0]     out_slot_q;
  logic                  out_last_q;
  logic [TASK_SLOTS-1:0] hit;
  logic                  hit_any;
  logic                  fire_any;
  logic                  can_load;
  logic                  load;
  logic                  last_w;
  logic [31:0]           idx_w;

  assign hit      = tok_i & fire_i;
  assign hit_any  = |hit;
  assign fire_any = |fire_i;
  assign can_load = !out_valid_q || m_ready_i;
  // No other pending fire besides the token's cell: this one is the last
  assign last_w   = ~|(fire_i & ~tok_i);

  // Encode the one-hot hit into a slot index
  always_comb begin
    idx_w = '0;
    for (int i = 0; i < TASK_SLOTS; i++) begin
      if (hit[i]) begin
        idx_w = idx_w | 32'(i);
      end
    end
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and cell commands
  always_comb begin
    state_d   = state_q;
    s_ready_o = 1'b0;
    cmd_o     = '0;
    inject_o  = 1'b0;
    load      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i && (op_e'(s_op_i) == OP_TICK)) begin
          cmd_o.tick = 1'b1;
          cmd_o.step = 1'b1;
          inject_o   = 1'b1;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!fire_any) begin
          // Scan done: remove the token so the next tick starts clean
          cmd_o.clr = 1'b1;
          state_d   = ST_IDLE;
        end else if (hit_any) begin
          if (can_load) begin
            load       = 1'b1;
            cmd_o.take = 1'b1;
            cmd_o.step = 1'b1;
          end
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (m_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_slot_q <= idx_w[SLOT_W-1:0];
      out_last_q <= last_w;
    end
  end

  assign m_valid_o = out_valid_q;
  assign m_slot_o  = out_slot_q;
  assign m_last_o  = out_last_q;

endmodule

// ===== sv/ptd_checker.sv =====
// ============================================================================
// ptd_checker: port-level checks for the tick dispatcher
// Watches the top-level streams and is bound to the top level.
// ============================================================================
module ptd_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          s_axis_tuser,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [ptd_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input logic                          m_axis_tlast
);
  import ptd_pkg::*;

  logic s_acc;
  assign s_acc = s_axis_tvalid && s_axis_tready;

  // A stalled output transaction holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output transaction changed while stalled");

  // A create never blocks the input
  a_create_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && (op_e'(s_axis_tuser) == OP_CREATE) |=> s_axis_tready)
    else $error("input not ready after create");

  // A tick starts a scan that holds off the input
  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && (op_e'(s_axis_tuser) == OP_TICK) |=> !s_axis_tready)
    else $error("input ready right after tick");

  // New results only come out of a scan
  a_out_from_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result appeared outside a scan");

  // Padding bits of the result stay zero
  a_out_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[M_TDATA_W-1:SLOT_W] == '0))
    else $error("nonzero padding in result");

endmodule

bind periodic_task_tick_dispatcher_unit ptd_checker u_ptd_checker (.*);

// ===== dv/tb_periodic_task_tick_dispatcher_unit.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_periodic_task_tick_dispatcher_unit: self-checking bench for the dispatcher
// Drives create and tick transactions with random gaps. A task table in the
// bench works out which slots fire on each tick, and each output transaction
// is checked against the oldest predicted fire.
// ============================================================================
module tb_periodic_task_tick_dispatcher_unit;
  import ptd_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_FIRED   = 8;
  localparam int HOLD_CYCLES = 200;
  localparam int RAND_ITEMS  = 380;

  // One predicted output transaction
  typedef struct packed {
    logic [SLOT_W-1:0] fired_slot;
    logic              last_fired;
  } fire_rec_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  // [2:0] slot, [3] task_present, [19:4] period, [35:20] initial_delay
  logic [S_TDATA_W-1:0] s_axis_tdata;
  // [0] operation
  logic                 s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  // [2:0] fired_slot
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 m_axis_tlast;

  // Bench copy of the task table
  logic              tbl_present   [TASK_SLOTS];
  logic [CD_W-1:0]   tbl_period    [TASK_SLOTS];
  logic [CD_W-1:0]   tbl_countdown [TASK_SLOTS];

  fire_rec_t fired_q[$];
  fire_rec_t want;
  int        errors      = 0;
  int        cycle_count = 0;
  int        hold_cycles = 0;
  bit        gaps_on     = 1'b1;
  bit        stalls_on   = 1'b1;

  periodic_task_tick_dispatcher_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Output check: every accepted transaction against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (fired_q.size() == 0) begin
        $error("fired_slot %0d arrived with none expected", m_axis_tdata[SLOT_W-1:0]);
        errors++;
      end else begin
        want = fired_q.pop_front();
        if (m_axis_tdata[SLOT_W-1:0] !== want.fired_slot) begin
          $error("fired_slot mismatch: expected %0d, actual %0d",
                 want.fired_slot, m_axis_tdata[SLOT_W-1:0]);
          errors++;
        end
        if (m_axis_tlast !== want.last_fired) begin
          $error("last_fired mismatch: expected %0d, actual %0d",
                 want.last_fired, m_axis_tlast);
          errors++;
        end
      end
    end
  end

  // Receiver: random stall per transaction, or a long hold when requested
  initial begin : receiver
    int stall;
    m_axis_tready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_cycles > 0) begin
        stall       = hold_cycles;
        hold_cycles = 0;
      end else begin
        stall = stalls_on ? $urandom_range(0, 6) : 0;
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // Offer one transaction, wait for acceptance, then update the task table
  task automatic send_item(input op_e op, input logic [SLOT_W-1:0] slot,
                           input logic present, input logic [CD_W-1:0] period,
                           input logic [CD_W-1:0] delay);
    int                gap;
    logic [SLOT_W-1:0] hits[$];
    gap = gaps_on ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {4'b0, delay, period, present, slot};
    do @(posedge clk_i); while (!s_axis_tready);

    if (op == OP_CREATE) begin
      if (int'(slot) < TASK_SLOTS) begin
        tbl_present[slot]   = present;
        tbl_period[slot]    = period;
        tbl_countdown[slot] = delay;
      end
    end else begin
      // Tick: scan in slot order; present zero countdowns fire and reload
      for (int i = 0; i < TASK_SLOTS; i++) begin
        if (tbl_countdown[i] == '0) begin
          if (tbl_present[i]) begin
            tbl_countdown[i] = tbl_period[i] - 1'b1;
            if (hits.size() < MAX_FIRED) hits.push_back(SLOT_W'(i));
          end
        end else begin
          tbl_countdown[i] = tbl_countdown[i] - 1'b1;
        end
      end
      foreach (hits[k])
        fired_q.push_back('{fired_slot: hits[k], last_fired: (k == hits.size() - 1)});
    end
  endtask

  // Release the input and let every predicted fire come out
  task automatic wait_all_fired();
    s_axis_tvalid <= 1'b0;
    while (fired_q.size() != 0) @(posedge clk_i);
  endtask

  // Empty table after reset: ticks fire nothing, tick fields are ignored
  task automatic test_idle_ticks();
    send_item(OP_TICK, '0, 1'b0, '0, '0);
    send_item(OP_TICK, '1, 1'b1, 16'hFFFF, 16'hFFFF);
    wait_all_fired();
  endtask

  // Zero and full period, absent slots with zero and nonzero countdowns,
  // delayed first firing, largest delay
  task automatic test_fire_rules();
    send_item(OP_CREATE, 3'd0, 1'b1, 16'h0000, 16'h0000);
    send_item(OP_CREATE, 3'd7, 1'b1, 16'hFFFF, 16'h0000);
    send_item(OP_CREATE, 3'd3, 1'b0, 16'h0007, 16'h0000);
    send_item(OP_CREATE, 3'd5, 1'b0, 16'h0003, 16'h0002);
    send_item(OP_CREATE, 3'd2, 1'b1, 16'h0002, 16'h0001);
    send_item(OP_CREATE, 3'd4, 1'b1, 16'h0003, 16'hFFFF);
    send_item(OP_TICK, '1, 1'b1, 16'hFFFF, 16'hFFFF);
    send_item(OP_TICK, 3'd5, 1'b0, 16'h5A5A, 16'hA5A5);
    send_item(OP_TICK, '0, 1'b0, '0, '0);
    wait_all_fired();
  endtask

  // Every slot fires on the same tick
  task automatic test_all_slots_fire();
    for (int s = 0; s < 8; s++) send_item(OP_CREATE, SLOT_W'(s), 1'b1, 16'd1, 16'd0);
    send_item(OP_TICK, '0, 1'b0, '0, '0);
    send_item(OP_TICK, '0, 1'b0, '0, '0);
    wait_all_fired();
  endtask

  // Long receiver hold while ticks keep coming: the block must stall its input
  task automatic test_output_backpressure();
    gaps_on     = 1'b0;
    hold_cycles = HOLD_CYCLES;
    repeat (6) send_item(OP_TICK, '0, 1'b0, '0, '0);
    wait_all_fired();
    gaps_on = 1'b1;
  endtask

  // Random mix of creates and ticks, mostly short periods so slots fire often
  task automatic test_random_traffic();
    logic [CD_W-1:0] period;
    logic [CD_W-1:0] delay;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % 40 == 0) begin
        gaps_on   = ($urandom_range(0, 3) != 0);
        stalls_on = ($urandom_range(0, 3) != 0);
      end
      if ($urandom_range(0, 99) < 35) begin
        period = ($urandom_range(0, 9) < 8) ? CD_W'($urandom_range(0, 4)) : CD_W'($urandom());
        delay  = ($urandom_range(0, 9) < 8) ? CD_W'($urandom_range(0, 6)) : CD_W'($urandom());
        send_item(OP_CREATE, SLOT_W'($urandom_range(0, 7)), ($urandom_range(0, 4) != 0),
                  period, delay);
      end else begin
        send_item(OP_TICK, SLOT_W'($urandom()), 1'($urandom()), CD_W'($urandom()),
                  CD_W'($urandom()));
      end
    end
    wait_all_fired();
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
  endtask

  // Sequence of tests
  initial begin
    for (int i = 0; i < TASK_SLOTS; i++) begin
      tbl_present[i]   = 1'b0;
      tbl_period[i]    = '0;
      tbl_countdown[i] = '0;
    end
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_idle_ticks();
    test_fire_rules();
    test_all_slots_fire();
    test_output_backpressure();
    test_random_traffic();

    // Let any late output show up before the verdict
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/ptd_pkg.sv
sv/ptd_cell.sv
sv/ptd_ctrl.sv
sv/periodic_task_tick_dispatcher_unit.sv
sv/ptd_checker.sv
dv/tb_periodic_task_tick_dispatcher_unit.sv
